// ----- hdl/dhash_pkg.sv -----
// Package with shared constants, types and codes of the double-modulus substring hash.
`default_nettype none
package dhash_pkg;

  localparam int MAX_LEN = 1024;
  localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int IDX_W   = 10;
  localparam int CMP_W   = (LEN_W > IDX_W + 1) ? LEN_W : IDX_W + 1;
  localparam int VAL_W   = 31;
  localparam int MOD_W   = 32;
  localparam int ADD_W   = 33;
  localparam int DIV_W   = 63;
  localparam int CNT_W   = $clog2(DIV_W);

  localparam logic [VAL_W-1:0] BASE_ONE = VAL_W'(9973);
  localparam logic [VAL_W-1:0] BASE_TWO = VAL_W'(10007);

  localparam logic [VAL_W-1:0] MOD_ONE_RESET = VAL_W'(1099999997);
  localparam logic [VAL_W-1:0] MOD_TWO_RESET = VAL_W'(892846183);

  // Register decode on paddr[2].
  localparam logic REG_MOD_ONE = 1'b0;
  localparam logic REG_MOD_TWO = 1'b1;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_A,
    ST_READ_B,
    ST_READ_C,
    ST_RUN_START,
    ST_RUN_WAIT,
    ST_DELIVER
  } seq_state_t;

  // One request to the shared multiply-reduce unit: (a*b + addend) mod modulus.
  typedef struct packed {
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic [ADD_W-1:0] addend;
    logic [MOD_W-1:0] modulus;
  } mm_req_t;

endpackage
`default_nettype wire

// ----- hdl/double_mod_substring_hash_core.sv -----
// Top level: stream ports, APB registers, prefix/power tables and the item sequencer.
// An append or a query runs four passes through one shared multiply-reduce unit; a pass is a
// start, one product step, 63 one-bit reduction steps and a done strobe.
// An append holds the input through the accept, two table reads and the four passes; a good
// query through one more table read and the delivery, plus any wait for the sink.
// A clear, an unused code or a full-string append stays idle; a bad-range query goes to delivery.
// Reset (rst, synchronous, active high) empties the string and loads the modulus defaults;
// table contents are not cleared, since only entries below the length are ever read.
`default_nettype none
module double_mod_substring_hash_core
  import dhash_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // character[7:0], first_index[17:8], last_index[27:18]
  input  wire logic [1:0]  s_tuser,   // func[1:0]
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // hash_one[30:0], hash_two[61:31]
  output logic             m_tuser,   // status[0]
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration registers.
  logic [VAL_W-1:0] modulus_one;
  logic [VAL_W-1:0] modulus_two;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_one <= MOD_ONE_RESET;
      modulus_two <= MOD_TWO_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_MOD_ONE: modulus_one <= pwdata[VAL_W-1:0];
        REG_MOD_TWO: modulus_two <= pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MOD_ONE: prdata = {1'b0, modulus_one};
      REG_MOD_TWO: prdata = {1'b0, modulus_two};
      default:     prdata = '0;
    endcase
  end

  // Latched item and working values.
  seq_state_t       state, state_next;
  logic [1:0]       func;
  logic [7:0]       character;
  logic [IDX_W-1:0] first_index;
  logic [IDX_W-1:0] last_index;
  logic [LEN_W-1:0] length;
  logic [MOD_W-1:0] m1, m2;
  logic [VAL_W-1:0] p1, p2, w1, w2, q1, q2;
  logic [VAL_W-1:0] res1, res2;
  logic             bad_range;
  logic [1:0]       op_idx;
  logic             accept;

  // Block outputs from the sequencer.
  logic             unit_start;
  logic             load_out;

  // Shared unit.
  mm_req_t          req;
  logic             unit_busy;
  logic             unit_done;
  logic [VAL_W-1:0] unit_result;

  // Table ports.
  logic [ADDR_W-1:0] pre_raddr, pow_raddr, waddr;
  logic [VAL_W-1:0]  pre1_rdata, pre2_rdata, pow1_rdata, pow2_rdata;
  logic              we_pre1, we_pre2, we_pow1, we_pow2;

  logic [CMP_W-1:0] first_ext, last_ext, len_ext;
  logic             is_append;
  logic             zero_sel;
  logic             range_bad;
  logic             full;

  assign accept    = s_tvalid && s_tready;
  assign is_append = (func == FUNC_APPEND);
  assign first_ext = CMP_W'(first_index);
  assign last_ext  = CMP_W'(last_index);
  assign len_ext   = CMP_W'(length);
  assign full      = (length == LEN_W'(MAX_LEN));
  assign range_bad = (CMP_W'(s_tdata[27:18]) >= len_ext) ||
                     (s_tdata[17:8] > s_tdata[27:18]);
  // Entry zero of each table is a constant and is never held in memory.
  assign zero_sel  = is_append ? (length == '0) : (first_index == '0);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (s_tuser)
            FUNC_APPEND: state_next = full ? ST_IDLE : ST_READ_A;
            FUNC_QUERY:  state_next = range_bad ? ST_DELIVER : ST_READ_A;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ_A:    state_next = ST_READ_B;
      ST_READ_B:    state_next = is_append ? ST_RUN_START : ST_READ_C;
      ST_READ_C:    state_next = ST_RUN_START;
      ST_RUN_START: state_next = ST_RUN_WAIT;
      ST_RUN_WAIT: begin
        if (unit_done) begin
          if (op_idx != 2'd3) begin
            state_next = ST_RUN_START;
          end else begin
            state_next = is_append ? ST_IDLE : ST_DELIVER;
          end
        end
      end
      ST_DELIVER: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready   = 1'b0;
    unit_start = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE:      s_tready   = 1'b1;
      ST_RUN_START: unit_start = 1'b1;
      ST_DELIVER:   load_out   = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      length <= '0;
      op_idx <= '0;
    end else begin
      state <= state_next;
      if (accept && s_tuser == FUNC_CLEAR) begin
        length <= '0;
      end
      if (accept) begin
        op_idx <= '0;
      end else if (state == ST_RUN_WAIT && unit_done) begin
        op_idx <= op_idx + 2'd1;
        if (op_idx == 2'd3 && is_append) begin
          length <= length + LEN_W'(1);
        end
      end
    end
  end

  // Item fields, effective moduli and table reads.
  always_ff @(posedge clk) begin
    if (accept) begin
      func        <= s_tuser;
      character   <= s_tdata[7:0];
      first_index <= s_tdata[17:8];
      last_index  <= s_tdata[27:18];
      bad_range   <= range_bad;
      // A zero register acts as modulus 2^31.
      m1 <= (modulus_one == '0) ? (MOD_W'(1) << VAL_W) : MOD_W'(modulus_one);
      m2 <= (modulus_two == '0) ? (MOD_W'(1) << VAL_W) : MOD_W'(modulus_two);
    end
    if (state == ST_READ_B) begin
      p1 <= zero_sel ? '0 : pre1_rdata;
      p2 <= zero_sel ? '0 : pre2_rdata;
      w1 <= (is_append && zero_sel) ? VAL_W'(1) : pow1_rdata;
      w2 <= (is_append && zero_sel) ? VAL_W'(1) : pow2_rdata;
    end
    if (state == ST_READ_C) begin
      q1 <= pre1_rdata;
      q2 <= pre2_rdata;
    end
    if (state == ST_RUN_WAIT && unit_done) begin
      if (op_idx[1]) begin
        res2 <= unit_result;
      end else begin
        res1 <= unit_result;
      end
    end
  end

  // Read addresses: table index i lives at memory address i-1.
  always_comb begin
    if (state == ST_READ_B) begin
      pre_raddr = ADDR_W'(last_index);
    end else if (is_append) begin
      pre_raddr = ADDR_W'(length - LEN_W'(1));
    end else begin
      pre_raddr = ADDR_W'(first_index - IDX_W'(1));
    end
    if (is_append) begin
      pow_raddr = ADDR_W'(length - LEN_W'(1));
    end else begin
      pow_raddr = ADDR_W'(last_index - first_index);
    end
  end

  // Operand selection for the four passes.
  always_comb begin
    req = '0;
    if (is_append) begin
      case (op_idx)
        2'd0: req = '{a: p1, b: BASE_ONE, addend: ADD_W'(character), modulus: m1};
        2'd1: req = '{a: p2, b: BASE_TWO, addend: ADD_W'(character), modulus: m2};
        2'd2: req = '{a: w1, b: BASE_ONE, addend: '0, modulus: m1};
        default: req = '{a: w2, b: BASE_TWO, addend: '0, modulus: m2};
      endcase
    end else begin
      case (op_idx)
        2'd0: req = '{a: p1, b: w1, addend: '0, modulus: m1};
        2'd1: req = '{a: '0, b: '0,
                      addend: ADD_W'(q1) + ADD_W'(m1) - ADD_W'(res1), modulus: m1};
        2'd2: req = '{a: p2, b: w2, addend: '0, modulus: m2};
        default: req = '{a: '0, b: '0,
                         addend: ADD_W'(q2) + ADD_W'(m2) - ADD_W'(res2), modulus: m2};
      endcase
    end
  end

  dhash_mulmod u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (unit_start),
    .req    (req),
    .busy   (unit_busy),
    .done   (unit_done),
    .result (unit_result)
  );

  // Each append pass writes its own table at the new entry.
  assign waddr   = ADDR_W'(length);
  assign we_pre1 = is_append && state == ST_RUN_WAIT && unit_done && op_idx == 2'd0;
  assign we_pre2 = is_append && state == ST_RUN_WAIT && unit_done && op_idx == 2'd1;
  assign we_pow1 = is_append && state == ST_RUN_WAIT && unit_done && op_idx == 2'd2;
  assign we_pow2 = is_append && state == ST_RUN_WAIT && unit_done && op_idx == 2'd3;

  dhash_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_pre1 (
    .clk(clk), .we(we_pre1), .waddr(waddr), .wdata(unit_result),
    .raddr(pre_raddr), .rdata(pre1_rdata));
  dhash_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_pre2 (
    .clk(clk), .we(we_pre2), .waddr(waddr), .wdata(unit_result),
    .raddr(pre_raddr), .rdata(pre2_rdata));
  dhash_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_pow1 (
    .clk(clk), .we(we_pow1), .waddr(waddr), .wdata(unit_result),
    .raddr(pow_raddr), .rdata(pow1_rdata));
  dhash_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_pow2 (
    .clk(clk), .we(we_pow2), .waddr(waddr), .wdata(unit_result),
    .raddr(pow_raddr), .rdata(pow2_rdata));

  // Output register: holds a finished beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= bad_range ? '0 : {2'b00, res2, res1};
      m_tuser <= bad_range;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_W'(MAX_LEN))
    else $error("length beyond table depth");

  a_beat_from_deliver: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DELIVER))
    else $error("output beat not from a query");

  a_unit_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !unit_busy)
    else $error("input taken while the unit works");

  a_first_le_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ_A && !is_append) |-> (first_ext <= last_ext && last_ext < len_ext))
    else $error("table read with a bad range");

endmodule
`default_nettype wire

// ----- hdl/dhash_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dhash_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [$clog2(DEPTH)-1:0]       waddr,
  input  wire logic [WIDTH-1:0]               wdata,
  input  wire logic [$clog2(DEPTH)-1:0]       raddr,
  output logic      [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/dhash_mulmod.sv -----
// Shared multiply-reduce unit: one product, then a bit-serial restoring reduction.
`default_nettype none
module dhash_mulmod
  import dhash_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire mm_req_t          req,
  output logic                  busy,
  output logic                  done,
  output logic [VAL_W-1:0]      result
);

  mm_req_t            req_q;
  logic               mul_phase;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_W-1:0]   dividend;
  logic [MOD_W-1:0]   rem;
  logic [MOD_W:0]     rem_shift;
  logic [MOD_W:0]     rem_diff;
  logic [DIV_W-1:0]   product;

  assign product   = DIV_W'(req_q.a) * DIV_W'(req_q.b) + DIV_W'(req_q.addend);
  assign rem_shift = {rem, dividend[DIV_W-1]};
  assign rem_diff  = rem_shift - {1'b0, req_q.modulus};
  assign result    = rem[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      mul_phase <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy      <= 1'b1;
        mul_phase <= 1'b1;
      end else if (mul_phase) begin
        mul_phase <= 1'b0;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end else if (mul_phase) begin
      dividend <= product;
      rem      <= '0;
      cnt      <= CNT_W'(DIV_W - 1);
    end else if (busy) begin
      dividend <= {dividend[DIV_W-2:0], 1'b0};
      rem      <= rem_diff[MOD_W] ? rem_shift[MOD_W-1:0] : rem_diff[MOD_W-1:0];
      cnt      <= cnt - CNT_W'(1);
    end
  end

  // The partial remainder always stays below the modulus.
  a_rem_below_mod: assert property (@(posedge clk) disable iff (rst)
    (busy && !mul_phase && !$past(start && !busy)) |-> (rem < req_q.modulus))
    else $error("remainder not below modulus");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without work");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    (busy && start) |=> busy)
    else $error("start while busy disturbed the unit");

endmodule
`default_nettype wire
